// ===== sv/tfn_pkg.sv =====
// Shared constants for the triangle face normal pipeline.
package tfn_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;
  localparam int OUT_WIDTH       = 16;

  // Normalization limits: edges are brought below 2^31, cross products below 2^30.
  localparam int EDGE_LIMIT_BITS  = 31;
  localparam int CROSS_LIMIT_BITS = 30;

endpackage

// ===== sv/triangle_face_normal.sv =====
// QW, the square root width, grows with COORD_WIDTH up to 31, reached at the default settings.
// Throughput: one item per cycle while the output is not stalled; the square root and the three
// dividers retire one result bit per pipeline stage. A stall at the output freezes the whole pipeline.
// Reset clears only the valid bits; no item is in flight after reset.
module triangle_face_normal #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]        a_x_i,
  input  logic signed [COORD_WIDTH-1:0]        a_y_i,
  input  logic signed [COORD_WIDTH-1:0]        a_z_i,
  input  logic signed [COORD_WIDTH-1:0]        b_x_i,
  input  logic signed [COORD_WIDTH-1:0]        b_y_i,
  input  logic signed [COORD_WIDTH-1:0]        b_z_i,
  input  logic signed [COORD_WIDTH-1:0]        c_x_i,
  input  logic signed [COORD_WIDTH-1:0]        c_y_i,
  input  logic signed [COORD_WIDTH-1:0]        c_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_x_o,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_y_o,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_z_o,
  output logic                                 degenerate_o
);
  import tfn_pkg::*;

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int EW   = COORD_WIDTH + 1;
  localparam int EMW  = (EW > EDGE_LIMIT_BITS) ? EDGE_LIMIT_BITS : EW;
  localparam int S1W  = $clog2(EW + 1);
  localparam int PW   = 2 * EMW;
  localparam int XW   = PW + 2;
  localparam int XM   = PW + 1;
  localparam int S2W  = $clog2(XM + 1);
  localparam int RW   = (XM > CROSS_LIMIT_BITS) ? CROSS_LIMIT_BITS : XM;
  localparam int SW   = 2 * RW + 2;
  localparam int QW   = RW + 1;
  localparam int NW   = RW + F + 1;
  localparam int VW   = (F + 2 > OUT_WIDTH) ? F + 2 : OUT_WIDTH;
  localparam int NST  = QW + F + 12;
  localparam int AI [6] = '{1, 2, 2, 0, 0, 1};
  localparam int BI [6] = '{2, 1, 0, 2, 1, 0};

  typedef struct packed {
    logic [2:0][RW-1:0] r;
    logic [2:0]         s;
    logic               dg;
  } side_t;

  logic [NST-1:0] v_q;
  logic           adv;

  assign adv        = !v_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // Stage 1: edges.
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic signed [EW-1:0]          e1_q [3];
  logic signed [EW-1:0]          e2_q [3];

  assign pa = '{a_x_i, a_y_i, a_z_i};
  assign pb = '{b_x_i, b_y_i, b_z_i};
  assign pc = '{c_x_i, c_y_i, c_z_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EW'(pb[i]) - EW'(pa[i]);
        e2_q[i] <= EW'(pc[i]) - EW'(pa[i]);
      end
    end
  end

  // Stage 2: bring edge magnitudes below the edge limit.
  logic [EW-1:0]  m1 [3];
  logic [EW-1:0]  m2 [3];
  logic [EW-1:0]  om1;
  logic [S1W-1:0] bl1;
  logic [S1W-1:0] sh1;
  logic [EMW-1:0] fm1_q [3];
  logic [EMW-1:0] fm2_q [3];
  logic [2:0]     fs1_q;
  logic [2:0]     fs2_q;

  always_comb begin
    om1 = '0;
    for (int i = 0; i < 3; i++) begin
      m1[i] = e1_q[i][EW-1] ? EW'(-e1_q[i]) : EW'(e1_q[i]);
      m2[i] = e2_q[i][EW-1] ? EW'(-e2_q[i]) : EW'(e2_q[i]);
      om1   = om1 | m1[i] | m2[i];
    end
    bl1 = '0;
    for (int b = 0; b < EW; b++) begin
      if (om1[b]) bl1 = S1W'(b + 1);
    end
    sh1 = (int'(bl1) > EDGE_LIMIT_BITS) ? S1W'(int'(bl1) - EDGE_LIMIT_BITS) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        fm1_q[i] <= EMW'(m1[i] >> sh1);
        fm2_q[i] <= EMW'(m2[i] >> sh1);
        fs1_q[i] <= e1_q[i][EW-1];
        fs2_q[i] <= e2_q[i][EW-1];
      end
    end
  end

  // Stage 3: the six partial products of the cross product.
  logic [PW-1:0] pm_q [6];
  logic [5:0]    pn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < 6; p++) begin
        pm_q[p] <= PW'(fm2_q[AI[p]]) * PW'(fm1_q[BI[p]]);
        pn_q[p] <= fs2_q[AI[p]] ^ fs1_q[BI[p]];
      end
    end
  end

  // Stage 4: cross product.
  logic signed [XW-1:0] sp [6];
  logic signed [XW-1:0] cr_q [3];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      sp[p] = pn_q[p] ? -$signed({2'b00, pm_q[p]}) : $signed({2'b00, pm_q[p]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= sp[2*i] - sp[2*i+1];
      end
    end
  end

  // Stage 5: sign and magnitude.
  logic [XM-1:0] cm_q [3];
  logic [2:0]    cs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cs_q[i] <= cr_q[i][XW-1];
        cm_q[i] <= cr_q[i][XW-1] ? XM'(-cr_q[i]) : XM'(cr_q[i]);
      end
    end
  end

  // Stage 6: shift count for the cross product and the degenerate test.
  logic [XM-1:0]  om2;
  logic [S2W-1:0] bl2;
  logic [XM-1:0]  cm6_q [3];
  logic [2:0]     cs6_q;
  logic [S2W-1:0] sh2_q;
  logic           dg6_q;

  always_comb begin
    om2 = cm_q[0] | cm_q[1] | cm_q[2];
    bl2 = '0;
    for (int b = 0; b < XM; b++) begin
      if (om2[b]) bl2 = S2W'(b + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cm6_q <= cm_q;
      cs6_q <= cs_q;
      sh2_q <= (int'(bl2) > CROSS_LIMIT_BITS) ? S2W'(int'(bl2) - CROSS_LIMIT_BITS) : '0;
      dg6_q <= (om2 == '0);
    end
  end

  // Stage 7: reduced components.
  side_t s7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s7_q.r[i] <= RW'(cm6_q[i] >> sh2_q);
      end
      s7_q.s  <= cs6_q;
      s7_q.dg <= dg6_q;
    end
  end

  // Stage 8: squares. Stage 9: sum of squares.
  logic [2*RW-1:0] sq_q [3];
  side_t           s8_q;
  logic [SW-1:0]   sum_q;
  side_t           s9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*RW)'(s7_q.r[i]) * (2*RW)'(s7_q.r[i]);
      end
      s8_q  <= s7_q;
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      s9_q  <= s8_q;
    end
  end

  // Square root, one result bit per stage.
  logic [SW-1:0] qn_q [QW];
  logic [SW-1:0] qr_q [QW];
  side_t         qs_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_sqrt
    localparam int K = QW - 1 - j;
    logic [SW-1:0] n_in;
    logic [SW-1:0] r_in;
    logic [SW-1:0] bitv;
    side_t         s_in;

    if (j == 0) begin : g_first
      assign n_in = sum_q;
      assign r_in = '0;
      assign s_in = s9_q;
    end else begin : g_next
      assign n_in = qn_q[j-1];
      assign r_in = qr_q[j-1];
      assign s_in = qs_q[j-1];
    end

    assign bitv = SW'(1) << (2 * K);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (n_in >= r_in + bitv) begin
          qn_q[j] <= n_in - r_in - bitv;
          qr_q[j] <= (r_in >> 1) + bitv;
        end else begin
          qn_q[j] <= n_in;
          qr_q[j] <= r_in >> 1;
        end
        qs_q[j] <= s_in;
      end
    end
  end

  // Numerators with the rounding term.
  logic [QW-1:0]      len;
  logic [2:0][NW-1:0] num_q;
  logic [QW-1:0]      nlen_q;
  side_t              ns_q;

  assign len = qr_q[QW-1][QW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (NW'(qs_q[QW-1].r[i]) << F) + NW'(len >> 1);
      end
      nlen_q <= len;
      ns_q   <= qs_q[QW-1];
    end
  end

  // Three restoring dividers, one quotient bit per stage.
  logic [2:0][NW-1:0] rm_q [F+1];
  logic [2:0][F:0]    qt_q [F+1];
  logic [QW-1:0]      dl_q [F+1];
  side_t              ds_q [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_div
    localparam int K = F - j;
    logic [2:0][NW-1:0] rm_in;
    logic [2:0][F:0]    qt_in;
    logic [QW-1:0]      dl_in;
    side_t              ds_in;
    logic [NW-1:0]      dv;

    if (j == 0) begin : g_first
      assign rm_in = num_q;
      assign qt_in = '0;
      assign dl_in = nlen_q;
      assign ds_in = ns_q;
    end else begin : g_next
      assign rm_in = rm_q[j-1];
      assign qt_in = qt_q[j-1];
      assign dl_in = dl_q[j-1];
      assign ds_in = ds_q[j-1];
    end

    assign dv = NW'(dl_in) << K;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (rm_in[i] >= dv) begin
            rm_q[j][i]    <= rm_in[i] - dv;
            qt_q[j][i]    <= qt_in[i] | ((F+1)'(1) << K);
          end else begin
            rm_q[j][i]    <= rm_in[i];
            qt_q[j][i]    <= qt_in[i];
          end
        end
        dl_q[j] <= dl_in;
        ds_q[j] <= ds_in;
      end
    end
  end

  // Output register.
  logic [VW-1:0]        val [3];
  logic [OUT_WIDTH-1:0] nx_q;
  logic [OUT_WIDTH-1:0] ny_q;
  logic [OUT_WIDTH-1:0] nz_q;
  logic                 dg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = ds_q[F].s[i] ? -VW'(qt_q[F][i]) : VW'(qt_q[F][i]);
      if (ds_q[F].dg) val[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= val[0][OUT_WIDTH-1:0];
      ny_q <= val[1][OUT_WIDTH-1:0];
      nz_q <= val[2][OUT_WIDTH-1:0];
      dg_q <= ds_q[F].dg;
    end
  end

  assign norm_x_o     = nx_q;
  assign norm_y_o     = ny_q;
  assign norm_z_o     = nz_q;
  assign degenerate_o = dg_q;

endmodule

// ===== sv/tfn_checker.sv =====
// Port-level checks for the triangle face normal block and their binding.
module tfn_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_x_o,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_y_o,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0] norm_z_o,
  input logic                                 degenerate_o
);
  import tfn_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("waiting input item withdrawn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(norm_x_o) &&
      $stable(norm_y_o) && $stable(norm_z_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0)
    else $error("degenerate item with nonzero normal");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

// ===== bench/triangle_face_normal_tb.sv =====
// Testbench for triangle_face_normal: directed and random triangles checked by a normal predictor.
`timescale 1ns / 1ps

module triangle_face_normal_tb;

  localparam int CW = tfn_pkg::COORD_WIDTH_DEF;
  localparam int FB = tfn_pkg::FRAC_BITS_DEF;
  localparam int OW = tfn_pkg::OUT_WIDTH;
  localparam int NUM_RANDOM = 2000;
  localparam int LATENCY = 31 + FB + 12;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic signed [OW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  typedef struct {
    tri_t    corners;
    logic    known;
    normal_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  tri_t tri_q = '0;
  logic in_ready_o, out_valid_o, degenerate_o;
  logic signed [OW-1:0] norm_x_o, norm_y_o, norm_z_o;

  normal_t normal_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int degenerate_seen = 0;
  bit sending_done = 1'b0;
  bit hold_off = 1'b0;

  always #4 clk_i = ~clk_i;

  triangle_face_normal u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a_x_i(tri_q.ax), .a_y_i(tri_q.ay), .a_z_i(tri_q.az),
    .b_x_i(tri_q.bx), .b_y_i(tri_q.by), .b_z_i(tri_q.bz),
    .c_x_i(tri_q.cx), .c_y_i(tri_q.cy), .c_z_i(tri_q.cz),
    .out_valid_o, .out_ready_i,
    .norm_x_o, .norm_y_o, .norm_z_o, .degenerate_o
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    longint e1[3], e2[3], cr[3];
    longint unsigned peak, len, total, m, q;
    int sh;
    normal_t r;
    e1[0] = longint'(t.bx) - t.ax; e1[1] = longint'(t.by) - t.ay;
    e1[2] = longint'(t.bz) - t.az;
    e2[0] = longint'(t.cx) - t.ax; e2[1] = longint'(t.cy) - t.ay;
    e2[2] = longint'(t.cz) - t.az;
    // Edges of 17 bits never need the edge shrink at this coordinate width.
    cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
    cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
    cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
    peak = 0;
    for (int i = 0; i < 3; i++) if (abs64(cr[i]) > peak) peak = abs64(cr[i]);
    r = '0;
    if (peak == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sh = 0;
    while ((peak >> sh) >= (64'd1 << 30)) sh++;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      m = abs64(cr[i]) >> sh;
      total += m * m;
    end
    len = root_floor(total);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      m = abs64(cr[i]) >> sh;
      q = ((m << FB) + (len >> 1)) / len;
      if (cr[i] < 0) q = -q;
      if (i == 0) r.nx = q[OW-1:0];
      else if (i == 1) r.ny = q[OW-1:0];
      else r.nz = q[OW-1:0];
    end
    return r;
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    logic [5*32-1:0] raw;
    int mode;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(tri_t)-1:0];
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      t.bx = t.ax; t.by = t.ay; t.bz = t.az;
    end else if (mode == 1) begin
      t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
    end else if (mode < 5) begin
      // Small triangles near the first corner keep the cross product short.
      t.bx = CW'(t.ax + $signed(CW'($urandom_range(0, 15))) - 8);
      t.by = CW'(t.ay + $signed(CW'($urandom_range(0, 15))) - 8);
      t.bz = CW'(t.az + $signed(CW'($urandom_range(0, 15))) - 8);
      t.cx = CW'(t.ax + $signed(CW'($urandom_range(0, 15))) - 8);
      t.cy = CW'(t.ay + $signed(CW'($urandom_range(0, 15))) - 8);
      t.cz = CW'(t.az + $signed(CW'($urandom_range(0, 15))) - 8);
    end
    return t;
  endfunction

  task automatic send_triangle(tri_t t, normal_t want);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tri_q <= t;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    normal_queue.push_back(want);
    @(negedge clk_i);
  endtask

  initial begin
    row_t rows[$];
    row_t row;
    tri_t t;
    localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [OW-1:0] ONE = OW'(1 << FB);

    row.known = 1'b1;
    row.corners = '0;
    row.want = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    rows.push_back(row);
    row.corners = '{ax: MAXC, ay: MAXC, az: MAXC, bx: MAXC, by: MAXC, bz: MAXC,
                    cx: MINC, cy: MINC, cz: MINC};
    rows.push_back(row);
    row.corners = '{ax: MINC, ay: MAXC, az: 0, bx: MAXC, by: MINC, bz: 0,
                    cx: 0, cy: 0, cz: 0};
    row.want = '{nx: '0, ny: '0, nz: -ONE, degen: 1'b0};
    rows.push_back(row);
    // Right triangle in the xy plane: e2 x e1 points down z.
    row.corners = '{ax: 0, ay: 0, az: 0, bx: 256, by: 0, bz: 0, cx: 0, cy: 256, cz: 0};
    row.want = '{nx: '0, ny: '0, nz: -ONE, degen: 1'b0};
    rows.push_back(row);
    row.corners = '{ax: 0, ay: 0, az: 0, bx: 0, by: 256, bz: 0, cx: 0, cy: 0, cz: 256};
    row.want = '{nx: -ONE, ny: '0, nz: '0, degen: 1'b0};
    rows.push_back(row);
    row.corners = '{ax: 0, ay: 0, az: 0, bx: 0, by: 0, bz: 256, cx: 256, cy: 0, cz: 0};
    row.want = '{nx: '0, ny: -ONE, nz: '0, degen: 1'b0};
    rows.push_back(row);
    row.known = 1'b0;
    row.corners = '{ax: MINC, ay: MINC, az: MINC, bx: MAXC, by: MINC, bz: MINC,
                    cx: MINC, cy: MAXC, cz: MINC};
    rows.push_back(row);
    row.corners = '{ax: MAXC, ay: MINC, az: MAXC, bx: MINC, by: MAXC, bz: MAXC,
                    cx: MAXC, cy: MAXC, cz: MINC};
    rows.push_back(row);
    row.corners = '{ax: -1, ay: -1, az: -1, bx: 0, by: -1, bz: 0, cx: -1, cy: 0, cz: 0};
    rows.push_back(row);
    row.corners = '{ax: 5, ay: -3, az: 7, bx: 6, by: -3, bz: 7, cx: 5, cy: -3, cz: 8};
    rows.push_back(row);
    row.corners = '{ax: MINC, ay: MAXC, az: MINC, bx: MAXC, by: MINC, bz: MAXC,
                    cx: MAXC, cy: MAXC, cz: MAXC};
    rows.push_back(row);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        send_triangle(rows[i].corners, rows[i].want);
      end else begin
        send_triangle(rows[i].corners, face_normal(rows[i].corners));
      end
    end
    hold_off = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 100) hold_off = 1'b1;
      t = random_triangle();
      send_triangle(t, face_normal(t));
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (LATENCY * 3) @(negedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    normal_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{nx: norm_x_o, ny: norm_y_o, nz: norm_z_o, degen: degenerate_o};
      results_seen++;
      if (degenerate_o) degenerate_seen++;
      if (normal_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = normal_queue.pop_front();
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
            got.degen !== want.degen) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (normal_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 2) @(posedge clk_i);
    $display("Checked %0d normals, %0d degenerate, with stalls on both sides.",
             results_seen, degenerate_seen);
    if (mismatches == 0 && normal_queue.size() == 0) begin
      $display("triangle_face_normal test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("triangle_face_normal test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("triangle_face_normal test failed");
    $finish;
  end

endmodule
